FILE: hdl/dqb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dqb_pkg
// shared types and constants of the dns query builder: beat payloads,
// sequencer states and configuration register map
// ----------------------------------------------------------------------------
package dqb_pkg;

    localparam int MAX_LABEL_DEF = 32;
    localparam int HDR_BYTES     = 12;
    localparam int TAIL_BYTES    = 5;
    localparam int CFG_ADDR_W    = 4;

    localparam logic [7:0] DOT_CHAR = 8'h2E;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [7:0] name_char;
        logic       is_last_char;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       end_of_packet;
        logic       label_overflow;
    } out_beat_t;

    typedef enum logic [1:0] {
        REG_TRANSACTION_ID    = 2'd0,
        REG_RECURSION_DESIRED = 2'd1,
        REG_QUERY_TYPE        = 2'd2,
        REG_QUERY_CLASS       = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR,
        S_PROC,
        S_FLEN,
        S_FDATA,
        S_TAIL
    } state_t;

endpackage
`default_nettype wire

FILE: hdl/dns_query_builder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dns_query_builder
// turns a dotted domain name, one character per beat, into the bytes of a
// dns query packet
// ----------------------------------------------------------------------------
// The first character of a name starts a packet with the 12-byte header
// (transaction id, flags with the rd bit, one question, zero other counts).
// Characters collect in a row of MAX_LABEL byte cells until a dot or the last
// character; each non-empty label then leaves as a length byte and its
// characters, drained from the head of the row one cell shift per byte.
// Characters beyond MAX_LABEL in a label are dropped and flagged in
// label_overflow on the end beat. The last character is followed by a zero
// byte, query type and query class. Output is one byte per cycle through an
// output register while the output side does not stall; a plain character
// is accepted, then stored, the first character of a name adds the header,
// a dot adds the length byte and the label, and the last character adds
// those and the five tail bytes. The input is stalled while a character
// is being worked on. Register writes apply to bytes emitted after the
// write; write them only between names.
// ----------------------------------------------------------------------------
module dns_query_builder #(
    parameter int MAX_LABEL = dqb_pkg::MAX_LABEL_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // name characters
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire dqb_pkg::in_beat_t              in_data,
    // packet bytes
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output dqb_pkg::out_beat_t                  out_data,
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [dqb_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int LEN_W = $clog2(MAX_LABEL + 1);

    // configuration registers
    logic [15:0] tid_reg;
    logic        rd_reg;
    logic [15:0] qtype_reg;
    logic [15:0] qclass_reg;

    dqb_pkg::cfg_reg_t cfg_sel;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign cfg_sel = dqb_pkg::cfg_reg_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tid_reg    <= 16'h0000;
            rd_reg     <= 1'b1;
            qtype_reg  <= 16'h0001;
            qclass_reg <= 16'h0001;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                dqb_pkg::REG_TRANSACTION_ID:    tid_reg    <= pwdata[15:0];
                dqb_pkg::REG_RECURSION_DESIRED: rd_reg     <= pwdata[0];
                dqb_pkg::REG_QUERY_TYPE:        qtype_reg  <= pwdata[15:0];
                dqb_pkg::REG_QUERY_CLASS:       qclass_reg <= pwdata[15:0];
                default:                        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            dqb_pkg::REG_TRANSACTION_ID:    prdata = {16'h0000, tid_reg};
            dqb_pkg::REG_RECURSION_DESIRED: prdata = {31'h0, rd_reg};
            dqb_pkg::REG_QUERY_TYPE:        prdata = {16'h0000, qtype_reg};
            dqb_pkg::REG_QUERY_CLASS:       prdata = {16'h0000, qclass_reg};
            default:                        prdata = 32'h0;
        endcase
    end

    // sequencer state
    dqb_pkg::state_t    state_reg, state_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               hdr_sent_reg, hdr_sent_next;
    logic               ovf_reg, ovf_next;
    dqb_pkg::byte_t     ch_reg, ch_next;
    logic               last_reg, last_next;
    logic               out_valid_reg, out_valid_next;
    dqb_pkg::out_beat_t out_data_reg, out_data_next;

    // label row control
    logic           wr_en;
    logic           shift;
    dqb_pkg::byte_t head;

    // scratch for the comb block
    logic             out_load;
    logic             is_dot;
    logic             do_store;
    logic [LEN_W-1:0] len_new;
    dqb_pkg::byte_t   hdr_byte;
    dqb_pkg::byte_t   tail_byte;

    dqb_label_chain #(
        .MAX_LABEL (MAX_LABEL)
    ) u_chain (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_pos  (len_reg),
        .wr_data (ch_reg),
        .shift   (shift),
        .head    (head)
    );

    // header byte for the current count
    always_comb
    begin
        case (cnt_reg)
            4'd0:    hdr_byte = tid_reg[15:8];
            4'd1:    hdr_byte = tid_reg[7:0];
            4'd2:    hdr_byte = {7'h00, rd_reg};
            4'd5:    hdr_byte = 8'h01;
            default: hdr_byte = 8'h00;
        endcase
    end

    // question tail: root label, type, class
    always_comb
    begin
        case (cnt_reg)
            4'd1:    tail_byte = qtype_reg[15:8];
            4'd2:    tail_byte = qtype_reg[7:0];
            4'd3:    tail_byte = qclass_reg[15:8];
            4'd4:    tail_byte = qclass_reg[7:0];
            default: tail_byte = 8'h00;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dqb_pkg::S_IDLE;
            cnt_reg       <= '0;
            len_reg       <= '0;
            hdr_sent_reg  <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            hdr_sent_reg  <= hdr_sent_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ch_reg       <= ch_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        hdr_sent_next  = hdr_sent_reg;
        ovf_next       = ovf_reg;
        ch_next        = ch_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        shift          = 1'b0;
        in_stall       = (state_reg != dqb_pkg::S_IDLE);
        out_load       = !out_valid_reg || !out_stall;
        is_dot         = (ch_reg == dqb_pkg::DOT_CHAR);
        do_store       = !is_dot && (len_reg < LEN_W'(MAX_LABEL));
        len_new        = do_store ? len_reg + 1'b1 : len_reg;

        // beat taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            dqb_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    ch_next    = in_data.name_char;
                    last_next  = in_data.is_last_char;
                    cnt_next   = '0;
                    state_next = hdr_sent_reg ? dqb_pkg::S_PROC : dqb_pkg::S_HDR;
                end
            end
            dqb_pkg::S_HDR:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{packet_byte: hdr_byte, end_of_packet: 1'b0,
                                       label_overflow: 1'b0};
                    cnt_next       = cnt_reg + 1'b1;
                    if (cnt_reg == 4'(dqb_pkg::HDR_BYTES - 1))
                    begin
                        hdr_sent_next = 1'b1;
                        state_next    = dqb_pkg::S_PROC;
                    end
                end
            end
            dqb_pkg::S_PROC:
            begin
                wr_en    = do_store;
                len_next = len_new;
                if (!is_dot && !do_store)
                begin
                    ovf_next = 1'b1;
                end
                cnt_next = '0;
                if ((is_dot || last_reg) && (len_new != '0))
                begin
                    state_next = dqb_pkg::S_FLEN;
                end
                else if (last_reg)
                begin
                    state_next = dqb_pkg::S_TAIL;
                end
                else
                begin
                    state_next = dqb_pkg::S_IDLE;
                end
            end
            dqb_pkg::S_FLEN:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{packet_byte: 8'(len_reg), end_of_packet: 1'b0,
                                       label_overflow: 1'b0};
                    state_next     = dqb_pkg::S_FDATA;
                end
            end
            dqb_pkg::S_FDATA:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{packet_byte: head, end_of_packet: 1'b0,
                                       label_overflow: 1'b0};
                    shift          = 1'b1;
                    len_next       = len_reg - 1'b1;
                    if (len_reg == LEN_W'(1))
                    begin
                        cnt_next   = '0;
                        state_next = last_reg ? dqb_pkg::S_TAIL : dqb_pkg::S_IDLE;
                    end
                end
            end
            dqb_pkg::S_TAIL:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{packet_byte: tail_byte,
                                       end_of_packet:
                                           (cnt_reg == 4'(dqb_pkg::TAIL_BYTES - 1)),
                                       label_overflow:
                                           (cnt_reg == 4'(dqb_pkg::TAIL_BYTES - 1))
                                           && ovf_reg};
                    cnt_next       = cnt_reg + 1'b1;
                    if (cnt_reg == 4'(dqb_pkg::TAIL_BYTES - 1))
                    begin
                        // packet done, next character opens a new one
                        hdr_sent_next = 1'b0;
                        ovf_next      = 1'b0;
                        len_next      = '0;
                        state_next    = dqb_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = dqb_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // overflow flag only ever rides on the end beat
    a_ovf_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.label_overflow || out_data.end_of_packet))
        else $error("label_overflow outside end beat");

    // label fill never runs past the row
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_LABEL))
        else $error("label length beyond row");

    // draining only happens with bytes left in the row
    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dqb_pkg::S_FDATA) |-> (len_reg != '0))
        else $error("drain of empty label");

    // the end beat rearms the header for the next name
    a_end_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dqb_pkg::S_TAIL && out_load
         && cnt_reg == 4'(dqb_pkg::TAIL_BYTES - 1))
        |=> (!hdr_sent_reg && !ovf_reg && len_reg == '0))
        else $error("packet state not cleared after end beat");
`endif

endmodule
`default_nettype wire

FILE: hdl/dqb_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dqb_cell
// one byte of the label buffer: loads a new character or takes the byte of
// its right-hand neighbor while the label drains
// ----------------------------------------------------------------------------
module dqb_cell (
    input  wire logic          clk,
    input  wire logic          load,
    input  wire logic          shift,
    input  wire dqb_pkg::byte_t din,
    input  wire dqb_pkg::byte_t from_next,
    output dqb_pkg::byte_t     q
);

    dqb_pkg::byte_t q_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= din;
        end
        else if (shift)
        begin
            q_reg <= from_next;
        end
    end

    assign q = q_reg;

endmodule
`default_nettype wire

FILE: hdl/dqb_label_chain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dqb_label_chain
// row of byte cells holding the current label; writes land at the fill
// position, reads come from cell zero as the row shifts toward it
// ----------------------------------------------------------------------------
module dqb_label_chain #(
    parameter int MAX_LABEL = dqb_pkg::MAX_LABEL_DEF,
    localparam int LEN_W    = $clog2(MAX_LABEL + 1)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [LEN_W-1:0] wr_pos,
    input  wire dqb_pkg::byte_t   wr_data,
    input  wire logic             shift,
    output dqb_pkg::byte_t        head
);

    dqb_pkg::byte_t cell_q [MAX_LABEL+1];

    // past the end of the row, zero shifts in
    assign cell_q[MAX_LABEL] = 8'h00;

    for (genvar i = 0; i < MAX_LABEL; i++)
    begin : g_cell
        dqb_cell u_cell (
            .clk       (clk),
            .load      (wr_en && (wr_pos == LEN_W'(i))),
            .shift     (shift),
            .din       (wr_data),
            .from_next (cell_q[i+1]),
            .q         (cell_q[i])
        );
    end

    assign head = cell_q[0];

endmodule
`default_nettype wire

FILE: test/dns_query_builder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_query_builder_tb
// self-checking bench for the dns query builder: a table of directed names
// after reset and at register extremes, then random names in phases with
// random register settings, random idling on both sides, a long output
// hold-off and drained pauses; every output beat is checked field by field
// against a packet predictor kept in step with accepted name beats
// ----------------------------------------------------------------------------
module dns_query_builder_tb;

    localparam int LABEL_CAP  = dqb_pkg::MAX_LABEL_DEF;
    localparam int RAND_BEATS = 420;   // random name beats to offer
    localparam int CALM_BEATS = 70;    // final stretch with no idling
    localparam int PHASE_MIN  = 60;    // name beats per register setting
    localparam int QUIET      = 8;     // cycles for a plain char to settle
    localparam int LONG_HOLD  = 300;   // output hold-off, in cycles
    localparam int TAIL_WAIT  = 64;    // extra cycles after the last byte
    localparam int DRAIN_MAX  = 20000; // bound on the final drain

    typedef enum logic [0:0] {
        ROW_CHAR,
        ROW_CFG
    } row_kind_t;

    // one row of the directed table: a char beat (possibly repeated), or a
    // register write; typed rows carry their packet bytes right-justified
    typedef struct {
        row_kind_t         kind;
        dqb_pkg::cfg_reg_t reg_sel;
        logic [31:0]       value;
        dqb_pkg::byte_t    ch;
        logic              last;
        int                rep;
        int                n;
        logic [135:0]      bytes;
    } row_t;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // dut ports, all known from time zero
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    dqb_pkg::in_beat_t              in_data = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    dqb_pkg::out_beat_t             out_data;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [dqb_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]                    pwdata = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    dns_query_builder #(
        .MAX_LABEL (LABEL_CAP)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // register shadow, reset values
    logic [15:0] cur_tid    = 16'h0000;
    logic        cur_rd     = 1'b1;
    logic [15:0] cur_qtype  = 16'h0001;
    logic [15:0] cur_qclass = 16'h0001;

    // packet predictor state
    dqb_pkg::byte_t lbl_buf [LABEL_CAP];
    int             lbl_len  = 0;
    logic           hdr_done = 1'b0;
    logic           ovf_seen = 1'b0;

    // packet bytes still to come, oldest first
    dqb_pkg::out_beat_t pending_bytes[$];
    // typed expectation for the next accepted beat, overrides the predictor
    dqb_pkg::out_beat_t typed_bytes[$];

    int   mismatches = 0;
    int   tx_pct = 10;       // chance of a sender gap after a beat
    int   rx_pct = 10;       // chance of a receiver stall burst
    logic calm = 1'b0;       // no idling on either side
    logic hold_req = 1'b0;   // ask the receiver for a long hold-off

    // ------------------------------------------------------------------
    // packet predictor
    // ------------------------------------------------------------------

    function automatic void put_byte(ref dqb_pkg::out_beat_t q[$],
                                     input dqb_pkg::byte_t v,
                                     input logic eop, input logic ovf);
        dqb_pkg::out_beat_t e;
        e.packet_byte    = v;
        e.end_of_packet  = eop;
        e.label_overflow = ovf;
        q = {q, e};
    endfunction

    // length byte then the buffered chars; empty labels leave nothing
    function automatic void flush_label(ref dqb_pkg::out_beat_t q[$]);
        if (lbl_len != 0)
        begin
            put_byte(q, dqb_pkg::byte_t'(lbl_len), 1'b0, 1'b0);
            for (int i = 0; i < lbl_len; i++)
                put_byte(q, lbl_buf[i], 1'b0, 1'b0);
            lbl_len = 0;
        end
    endfunction

    // bytes caused by one accepted name char
    function automatic void encode_char(dqb_pkg::in_beat_t b,
                                        ref dqb_pkg::out_beat_t q[$]);
        // first char of a name opens the packet with the header
        if (!hdr_done)
        begin
            put_byte(q, cur_tid[15:8], 1'b0, 1'b0);
            put_byte(q, cur_tid[7:0], 1'b0, 1'b0);
            put_byte(q, {7'b0, cur_rd}, 1'b0, 1'b0);
            put_byte(q, 8'h00, 1'b0, 1'b0);
            // one question, big-endian
            put_byte(q, 8'h00, 1'b0, 1'b0);
            put_byte(q, 8'h01, 1'b0, 1'b0);
            // answer, authority and additional counts are zero
            for (int i = 0; i < 6; i++)
                put_byte(q, 8'h00, 1'b0, 1'b0);
            hdr_done = 1'b1;
        end

        if (b.name_char == dqb_pkg::DOT_CHAR)
            flush_label(q);
        else if (lbl_len < LABEL_CAP)
        begin
            lbl_buf[lbl_len] = b.name_char;
            lbl_len++;
        end
        else
            ovf_seen = 1'b1;   // long label, char dropped

        // end of name: root label, type, class; next char starts afresh
        if (b.is_last_char)
        begin
            flush_label(q);
            put_byte(q, 8'h00, 1'b0, 1'b0);
            put_byte(q, cur_qtype[15:8], 1'b0, 1'b0);
            put_byte(q, cur_qtype[7:0], 1'b0, 1'b0);
            put_byte(q, cur_qclass[15:8], 1'b0, 1'b0);
            put_byte(q, cur_qclass[7:0], 1'b1, ovf_seen);
            hdr_done = 1'b0;
            ovf_seen = 1'b0;
            lbl_len  = 0;
        end
    endfunction

    // ------------------------------------------------------------------
    // directed table rows
    // ------------------------------------------------------------------

    function automatic row_t row_char(dqb_pkg::byte_t c, logic last, int rep);
        row_t r;
        r.kind    = ROW_CHAR;
        r.reg_sel = dqb_pkg::REG_TRANSACTION_ID;
        r.value   = '0;
        r.ch      = c;
        r.last    = last;
        r.rep     = rep;
        r.n       = 0;
        r.bytes   = '0;
        return r;
    endfunction

    function automatic row_t row_typed(dqb_pkg::byte_t c, logic last, int n,
                                       logic [135:0] bytes);
        row_t r;
        r       = row_char(c, last, 1);
        r.n     = n;
        r.bytes = bytes;
        return r;
    endfunction

    function automatic row_t row_reg(dqb_pkg::cfg_reg_t sel, logic [31:0] v);
        row_t r;
        r         = row_char(8'h00, 1'b0, 0);
        r.kind    = ROW_CFG;
        r.reg_sel = sel;
        r.value   = v;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // random idle burst after a beat, with valid held low
    task automatic sender_gap();
        if (!calm && $urandom_range(0, 99) < tx_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
    endtask

    // offer one name beat from a falling edge, predict on acceptance
    task automatic send_beat(dqb_pkg::in_beat_t b);
        dqb_pkg::out_beat_t got[$];
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        encode_char(b, got);
        if (typed_bytes.size() != 0)
        begin
            got = typed_bytes;
            typed_bytes = {};
        end
        foreach (got[i])
            pending_bytes = {pending_bytes, got[i]};
        @(negedge clk);
        sender_gap();
    endtask

    // hold the sender until every expected byte is out, then let the
    // block finish any char still in flight
    task automatic drain_wait();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_bytes.size() != 0)
            @(negedge clk);
        repeat (QUIET) @(negedge clk);
    endtask

    // apb write: setup then access, register taken when pready is high
    task automatic write_reg(dqb_pkg::cfg_reg_t sel, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= dqb_pkg::CFG_ADDR_W'(sel) << 2;
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (sel)
            dqb_pkg::REG_TRANSACTION_ID:    cur_tid    = v[15:0];
            dqb_pkg::REG_RECURSION_DESIRED: cur_rd     = v[0];
            dqb_pkg::REG_QUERY_TYPE:        cur_qtype  = v[15:0];
            dqb_pkg::REG_QUERY_CLASS:       cur_qclass = v[15:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // register value biased toward the extremes, upper bits random too
    function automatic logic [31:0] reg_value();
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // one random name: mostly well-formed labels with random content,
    // sometimes long labels, empty labels, stray dots or plain noise
    task automatic make_name(ref dqb_pkg::in_beat_t q[$]);
        dqb_pkg::in_beat_t b;
        int                nlab;
        int                len;
        int                pick;
        q = {};
        b.is_last_char = 1'b0;
        if ($urandom_range(0, 9) == 0)
        begin
            // noise: any chars, dots now and then
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                b.name_char = ($urandom_range(0, 3) == 0)
                              ? dqb_pkg::DOT_CHAR
                              : dqb_pkg::byte_t'($urandom_range(0, 255));
                q = {q, b};
            end
        end
        else
        begin
            nlab = $urandom_range(1, 4);
            if ($urandom_range(0, 7) == 0)
            begin
                b.name_char = dqb_pkg::DOT_CHAR;   // leading dot
                q = {q, b};
            end
            for (int l = 0; l < nlab; l++)
            begin
                if (l != 0)
                begin
                    b.name_char = dqb_pkg::DOT_CHAR;
                    q = {q, b};
                end
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    len = 0;   // doubled dot
                else if (pick == 1)
                    len = $urandom_range(LABEL_CAP - 2, LABEL_CAP + 6);
                else
                    len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                begin
                    // any byte but the separator
                    b.name_char = dqb_pkg::byte_t'($urandom_range(0, 254));
                    if (b.name_char >= dqb_pkg::DOT_CHAR)
                        b.name_char = b.name_char + 8'd1;
                    q = {q, b};
                end
            end
            if ($urandom_range(0, 5) == 0)
            begin
                b.name_char = dqb_pkg::DOT_CHAR;   // trailing dot
                q = {q, b};
            end
        end
        if (q.size() == 0)
        begin
            b.name_char = dqb_pkg::byte_t'($urandom_range(0, 255));
            q = {q, b};
        end
        q[q.size() - 1].is_last_char = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // receiver side: random stall bursts, one long hold-off on request
    // ------------------------------------------------------------------

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < rx_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // output checker: every accepted beat against the oldest expectation
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        dqb_pkg::out_beat_t exp_beat;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected packet beat %02h eop %0b ovf %0b",
                       out_data.packet_byte, out_data.end_of_packet,
                       out_data.label_overflow);
                mismatches++;
            end
            else
            begin
                exp_beat = pending_bytes.pop_front();
                if (out_data.packet_byte !== exp_beat.packet_byte)
                begin
                    $error("packet_byte expected %02h got %02h",
                           exp_beat.packet_byte, out_data.packet_byte);
                    mismatches++;
                end
                if (out_data.end_of_packet !== exp_beat.end_of_packet)
                begin
                    $error("end_of_packet expected %0b got %0b",
                           exp_beat.end_of_packet, out_data.end_of_packet);
                    mismatches++;
                end
                if (out_data.label_overflow !== exp_beat.label_overflow)
                begin
                    $error("label_overflow expected %0b got %0b",
                           exp_beat.label_overflow, out_data.label_overflow);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // run limit
    // ------------------------------------------------------------------

    initial
    begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        row_t               dir_rows[$];
        dqb_pkg::in_beat_t  name_q[$];
        dqb_pkg::in_beat_t  b;
        dqb_pkg::out_beat_t e;
        int                 rand_beats;
        int                 phase_beats;
        int                 phase;

        // directed names; hex columns are whole packets, header bytes or a label
        dir_rows = {
            // header with reset registers
            row_typed(8'h61, 1'b0, 12, 136'h0000_0100_0001_0000_0000_0000),
            // label of one char
            row_typed(dqb_pkg::DOT_CHAR, 1'b0, 2, 136'h0161),
            // zero char is data, not a terminator
            row_char(8'h00, 1'b0, 1),
            row_char(8'hFF, 1'b0, 1),
            row_char(dqb_pkg::DOT_CHAR, 1'b0, 1),
            // doubled dot gives nothing
            row_char(dqb_pkg::DOT_CHAR, 1'b0, 1),
            // long label, chars past the cap dropped
            row_char(8'h78, 1'b0, LABEL_CAP + 2),
            // trailing dot on the last beat, overflow on the end byte
            row_char(dqb_pkg::DOT_CHAR, 1'b1, 1),
            // name of one dot: header, root, type, class
            row_typed(dqb_pkg::DOT_CHAR, 1'b1, 17,
                      136'h0000_0100_0001_0000_0000_0000_00_0001_0001),
            // label of exactly the cap, ended by the last char itself
            row_char(8'h63, 1'b0, LABEL_CAP - 1),
            row_char(8'h64, 1'b1, 1),
            // leading dot
            row_char(dqb_pkg::DOT_CHAR, 1'b0, 1),
            row_char(8'h80, 1'b0, 1),
            row_char(8'h01, 1'b1, 1),
            // registers at one extreme
            row_reg(dqb_pkg::REG_TRANSACTION_ID, 32'h0000_FFFF),
            row_reg(dqb_pkg::REG_RECURSION_DESIRED, 32'h0000_0000),
            row_reg(dqb_pkg::REG_QUERY_TYPE, 32'h0000_FFFF),
            row_reg(dqb_pkg::REG_QUERY_CLASS, 32'h0000_0000),
            row_typed(dqb_pkg::DOT_CHAR, 1'b1, 17,
                      136'hFFFF_0000_0001_0000_0000_0000_00_FFFF_0000),
            // and at the other
            row_reg(dqb_pkg::REG_TRANSACTION_ID, 32'h0000_0000),
            row_reg(dqb_pkg::REG_RECURSION_DESIRED, 32'h0000_0001),
            row_reg(dqb_pkg::REG_QUERY_TYPE, 32'h0000_0000),
            row_reg(dqb_pkg::REG_QUERY_CLASS, 32'h0000_FFFF),
            row_typed(dqb_pkg::DOT_CHAR, 1'b1, 17,
                      136'h0000_0100_0001_0000_0000_0000_00_0000_FFFF),
            // single char name
            row_char(8'h41, 1'b1, 1)
        };

        // reset, released on a falling edge
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // walk the directed table
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                drain_wait();
                write_reg(dir_rows[i].reg_sel, dir_rows[i].value);
            end
            else
            begin
                for (int k = 0; k < dir_rows[i].rep; k++)
                begin
                    b.name_char    = dir_rows[i].ch;
                    b.is_last_char = dir_rows[i].last;
                    for (int j = 0; j < dir_rows[i].n; j++)
                    begin
                        e.packet_byte    = dir_rows[i].bytes[(dir_rows[i].n - 1 - j) * 8 +: 8];
                        e.end_of_packet  = dir_rows[i].last && (j == dir_rows[i].n - 1);
                        e.label_overflow = 1'b0;
                        typed_bytes = {typed_bytes, e};
                    end
                    send_beat(b);
                end
            end
        end

        // random phases, each with its own registers and idling mix
        rand_beats = 0;
        phase = 0;
        while (rand_beats < RAND_BEATS)
        begin
            drain_wait();
            write_reg(dqb_pkg::REG_TRANSACTION_ID, reg_value());
            write_reg(dqb_pkg::REG_RECURSION_DESIRED, reg_value());
            write_reg(dqb_pkg::REG_QUERY_TYPE, reg_value());
            write_reg(dqb_pkg::REG_QUERY_CLASS, reg_value());
            case ($urandom_range(0, 2))
                0:       tx_pct = 0;
                1:       tx_pct = 5;
                default: tx_pct = 20;
            endcase
            case ($urandom_range(0, 2))
                0:       rx_pct = 0;
                1:       rx_pct = 5;
                default: rx_pct = 25;
            endcase
            calm = (rand_beats >= RAND_BEATS - CALM_BEATS);
            // long output hold-off while names keep coming
            if (phase == 1)
                hold_req = 1'b1;
            phase_beats = 0;
            while (phase_beats < PHASE_MIN)
            begin
                make_name(name_q);
                foreach (name_q[i])
                begin
                    send_beat(name_q[i]);
                    phase_beats++;
                    rand_beats++;
                    // the closing stretch runs with no idling at all
                    if (rand_beats >= RAND_BEATS - CALM_BEATS)
                        calm = 1'b1;
                    // now and then pause mid-name until the output is dry
                    if (!calm && $urandom_range(0, 79) == 0)
                        drain_wait();
                end
            end
            phase++;
        end

        // final drain, bounded
        in_valid <= 1'b0;
        for (int i = 0; i < DRAIN_MAX && pending_bytes.size() != 0; i++)
            @(negedge clk);
        if (pending_bytes.size() != 0)
        begin
            $error("%0d packet bytes never arrived", pending_bytes.size());
            mismatches++;
        end
        repeat (TAIL_WAIT) @(negedge clk);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
